/* rtl/core/radio_path_loss_estimator_macros.svh */
// Assertion macros shared by the path loss estimator RTL.
`ifndef RADIO_PATH_LOSS_ESTIMATOR_MACROS_SVH
`define RADIO_PATH_LOSS_ESTIMATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RPLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rple assertion failed");
`define RPLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rple assertion failed");
`else
`define RPLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/rple_pkg.sv */
// Types and constants of the radio path loss estimator.
package rple_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int LOG_ITERS  = 16;          // fraction bits of log2
    localparam int EXP_W      = 12;          // Q4.8 exponent
    localparam int MK_W       = 30;          // exponent times 10*log10(2)
    localparam int COND_W     = 28;
    localparam int XDIST_W    = 24;          // crossover register width
    localparam int LVL_W      = 16;          // Q8.8 dB / dBm

    localparam logic [17:0]      TEN_LOG10_2_Q16 = 18'd197283;
    localparam logic [EXP_W-1:0] NEAR_MULT       = 12'd512;
    localparam logic [EXP_W-1:0] FAR_MULT        = 12'd1024;

    localparam logic [1:0]             RST_MODEL_SELECT = 2'd0;
    localparam logic [COND_W-1:0]      RST_COND_LOS     = 28'd226439680;
    localparam logic [COND_W-1:0]      RST_COND_NLOS    = 28'd226439936;
    localparam logic [COND_W-1:0]      RST_COND_NLOS2   = 28'd226440013;
    localparam logic [COND_W-1:0]      RST_COND_NLOS3   = 28'd226440448;
    localparam logic [XDIST_W-1:0]     RST_CROSSOVER    = 24'd6434;
    localparam logic signed [LVL_W-1:0] RST_NEAR_OFFSET = -16'sd10253;
    localparam logic signed [LVL_W-1:0] RST_FAR_OFFSET  = -16'sd3082;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODEL_SELECT = 4'd0,
        REG_COND_LOS     = 4'd1,
        REG_COND_NLOS    = 4'd2,
        REG_COND_NLOS2   = 4'd3,
        REG_COND_NLOS3   = 4'd4,
        REG_CROSSOVER    = 4'd5,
        REG_NEAR_OFFSET  = 4'd6,
        REG_FAR_OFFSET   = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODEL_LOG_DIST = 2'd0,
        MODEL_TWO_RAY  = 2'd1,
        MODEL_BYPASS   = 2'd2
    } model_t;

    typedef enum logic [1:0] {
        COND_LOS   = 2'd0,
        COND_NLOS  = 2'd1,
        COND_NLOS2 = 2'd2,
        COND_NLOS3 = 2'd3
    } link_cond_t;

    // Fields that ride along the log2 pipeline
    typedef struct packed {
        logic [MK_W-1:0]         mk;
        logic signed [LVL_W-1:0] offset;
        logic signed [LVL_W-1:0] tx;
        logic                    bypass;
    } side_t;

endpackage

/* rtl/core/radio_path_loss_estimator.sv */
// Radio path loss estimator: log-distance / two-ray / bypass received level, pipelined.
// One link enters per cycle while the skid buffer is empty. On its way to the output register
// one stage selects the condition terms, one finds the leading one of the distance, one
// normalizes it, sixteen squaring stages (one 31x31 multiplier each) produce the sixteen
// fraction bits of log2, and one multiplier stage scales the log by exponent*10*log10(2);
// rounding, offset add and saturation sit in front of the output register. A one-entry
// skid buffer behind the output lets the pipeline take another link while a result waits.
// A zero distance or model code 2 or 3 returns the transmit level unchanged. Configuration
// writes are always taken (cfg_ready is tied high); an index beyond 7 is ignored.
`include "radio_path_loss_estimator_macros.svh"
module radio_path_loss_estimator
    import rple_pkg::*;
#(
    parameter int DIST_INT_BITS = 16,
    parameter int FRAC_BITS     = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [DIST_INT_BITS+FRAC_BITS-1:0]  s_link_distance,
    input  logic [1:0]                          s_link_condition,
    input  logic signed [LVL_W-1:0]             s_tx_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [LVL_W-1:0]             m_rx_level,
    output logic                                m_saturated
);

    localparam int DW    = DIST_INT_BITS + FRAC_BITS;
    localparam int PW    = $clog2(DW);
    localparam int IW    = PW + 2;
    localparam int LW    = IW + LOG_ITERS;
    localparam int PRW   = MK_W + 1 + LW;
    localparam int LOSSW = PRW - 32;
    localparam int RW    = LOSSW + 2;
    localparam int CMPW  = (DW > XDIST_W) ? DW : XDIST_W;
    localparam logic signed [RW-1:0] LVL_MAX = RW'(32767);
    localparam logic signed [RW-1:0] LVL_MIN = -RW'(32768);

    // ---------------- configuration registers ----------------
    logic [1:0]              model_reg;
    logic [COND_W-1:0]       cond_los_reg, cond_nlos_reg, cond_nlos2_reg, cond_nlos3_reg;
    logic [XDIST_W-1:0]      crossover_reg;
    logic signed [LVL_W-1:0] near_offset_reg, far_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg       <= RST_MODEL_SELECT;
            cond_los_reg    <= RST_COND_LOS;
            cond_nlos_reg   <= RST_COND_NLOS;
            cond_nlos2_reg  <= RST_COND_NLOS2;
            cond_nlos3_reg  <= RST_COND_NLOS3;
            crossover_reg   <= RST_CROSSOVER;
            near_offset_reg <= RST_NEAR_OFFSET;
            far_offset_reg  <= RST_FAR_OFFSET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_MODEL_SELECT: model_reg       <= cfg_data[1:0];
                REG_COND_LOS:     cond_los_reg    <= cfg_data[COND_W-1:0];
                REG_COND_NLOS:    cond_nlos_reg   <= cfg_data[COND_W-1:0];
                REG_COND_NLOS2:   cond_nlos2_reg  <= cfg_data[COND_W-1:0];
                REG_COND_NLOS3:   cond_nlos3_reg  <= cfg_data[COND_W-1:0];
                REG_CROSSOVER:    crossover_reg   <= cfg_data[XDIST_W-1:0];
                REG_NEAR_OFFSET:  near_offset_reg <= cfg_data[LVL_W-1:0];
                REG_FAR_OFFSET:   far_offset_reg  <= cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;            // whole pipeline advances
    logic skid_v_reg;
    assign en      = !skid_v_reg;
    assign s_ready = en;

    // ---------------- stage 1: select condition terms ----------------
    logic [COND_W-1:0]       sel_word;
    logic [EXP_W-1:0]        sel_mult;
    logic signed [LVL_W-1:0] sel_offset;
    logic                    near_range;
    logic                    bypass_in;

    always_comb begin
        case (link_cond_t'(s_link_condition))
            COND_LOS:  sel_word = cond_los_reg;
            COND_NLOS: sel_word = cond_nlos_reg;
            COND_NLOS2: sel_word = cond_nlos2_reg;
            default:   sel_word = cond_nlos3_reg;
        endcase
        near_range = CMPW'(s_link_distance) < CMPW'(crossover_reg);
        bypass_in  = (s_link_distance == '0) || (model_reg[1] == 1'b1);
        case (model_t'(model_reg))
            MODEL_LOG_DIST: begin
                sel_mult   = sel_word[EXP_W-1:0];
                sel_offset = sel_word[COND_W-1:EXP_W];
            end
            MODEL_TWO_RAY: begin
                sel_mult   = near_range ? NEAR_MULT : FAR_MULT;
                sel_offset = near_range ? near_offset_reg : far_offset_reg;
            end
            default: begin
                sel_mult   = '0;
                sel_offset = '0;
            end
        endcase
    end

    logic                    s1_v_reg;
    logic [DW-1:0]           s1_dist_reg;
    logic [EXP_W-1:0]        s1_mult_reg;
    logic signed [LVL_W-1:0] s1_offset_reg;
    logic signed [LVL_W-1:0] s1_tx_reg;
    logic                    s1_bypass_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dist_reg   <= s_link_distance;
            s1_mult_reg   <= sel_mult;
            s1_offset_reg <= sel_offset;
            s1_tx_reg     <= s_tx_level;
            s1_bypass_reg <= bypass_in;
        end
    end

    // ---------------- stage 2: leading one, exponent scale ----------------
    logic [PW-1:0] lead_pos;
    always_comb begin
        lead_pos = '0;
        for (int i = 0; i < DW; i++) begin
            if (s1_dist_reg[i]) begin
                lead_pos = PW'(i);
            end
        end
    end

    logic          s2_v_reg;
    logic [DW-1:0] s2_dist_reg;
    logic [PW-1:0] s2_pos_reg;
    side_t         s2_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_dist_reg        <= s1_dist_reg;
            s2_pos_reg         <= lead_pos;
            s2_side_reg.mk     <= MK_W'(s1_mult_reg) * MK_W'(TEN_LOG10_2_Q16);
            s2_side_reg.offset <= s1_offset_reg;
            s2_side_reg.tx     <= s1_tx_reg;
            s2_side_reg.bypass <= s1_bypass_reg;
        end
    end

    // ---------------- stage 3: normalize to Q1.30 ----------------
    logic [DW+29:0] norm_wide;
    assign norm_wide = {s2_dist_reg, 30'b0} >> s2_pos_reg;

    logic                 lg_v_reg    [0:LOG_ITERS];
    logic [30:0]          lg_x_reg    [0:LOG_ITERS];
    logic [LOG_ITERS-1:0] lg_fr_reg   [0:LOG_ITERS];
    logic [PW-1:0]        lg_pos_reg  [0:LOG_ITERS];
    side_t                lg_side_reg [0:LOG_ITERS];

    always_ff @(posedge aclk) begin
        if (en) begin
            lg_x_reg[0]    <= norm_wide[30:0];
            lg_fr_reg[0]   <= '0;
            lg_pos_reg[0]  <= s2_pos_reg;
            lg_side_reg[0] <= s2_side_reg;
        end
    end

    // ---------------- squaring stages: one fraction bit each ----------------
    for (genvar k = 0; k < LOG_ITERS; k++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] sq_top;

        assign sq     = 62'(lg_x_reg[k]) * 62'(lg_x_reg[k]);
        assign sq_top = sq[61:30];

        always_ff @(posedge aclk) begin
            if (en) begin
                // mantissa reached two: emit a one and halve
                lg_x_reg[k+1]    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                lg_fr_reg[k+1]   <= {lg_fr_reg[k][LOG_ITERS-2:0], sq_top[31]};
                lg_pos_reg[k+1]  <= lg_pos_reg[k];
                lg_side_reg[k+1] <= lg_side_reg[k];
            end
        end
    end

    // ---------------- product stage: loss before rounding ----------------
    logic signed [IW-1:0] log_int;
    logic signed [LW-1:0] log_val;
    assign log_int = signed'(IW'(lg_pos_reg[LOG_ITERS])) - signed'(IW'(FRAC_BITS));
    assign log_val = {log_int, lg_fr_reg[LOG_ITERS]};

    logic                    pr_v_reg;
    logic signed [PRW-1:0]   pr_prod_reg;
    logic signed [LVL_W-1:0] pr_offset_reg;
    logic signed [LVL_W-1:0] pr_tx_reg;
    logic                    pr_bypass_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_prod_reg   <= signed'({1'b0, lg_side_reg[LOG_ITERS].mk}) * log_val;
            pr_offset_reg <= lg_side_reg[LOG_ITERS].offset;
            pr_tx_reg     <= lg_side_reg[LOG_ITERS].tx;
            pr_bypass_reg <= lg_side_reg[LOG_ITERS].bypass;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            for (int i = 0; i <= LOG_ITERS; i++) begin
                lg_v_reg[i] <= 1'b0;
            end
            pr_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg    <= s_valid;
            s2_v_reg    <= s1_v_reg;
            lg_v_reg[0] <= s2_v_reg;
            for (int i = 0; i < LOG_ITERS; i++) begin
                lg_v_reg[i+1] <= lg_v_reg[i];
            end
            pr_v_reg <= lg_v_reg[LOG_ITERS];
        end
    end

    // ---------------- round, add offset, saturate ----------------
    logic signed [PRW-1:0]   prod_rnd;
    logic signed [LOSSW-1:0] loss;
    logic signed [RW-1:0]    sum_full;
    logic signed [LVL_W-1:0] rx_next;
    logic                    sat_next;

    always_comb begin
        prod_rnd = pr_prod_reg + signed'(PRW'(33'h0_8000_0000));
        loss     = prod_rnd[PRW-1:32];
        sum_full = RW'(pr_tx_reg) + RW'(pr_offset_reg) - RW'(loss);
        if (pr_bypass_reg) begin
            rx_next  = pr_tx_reg;
            sat_next = 1'b0;
        end else if (sum_full > LVL_MAX) begin
            rx_next  = 16'sh7FFF;
            sat_next = 1'b1;
        end else if (sum_full < LVL_MIN) begin
            rx_next  = 16'sh8000;
            sat_next = 1'b1;
        end else begin
            rx_next  = sum_full[LVL_W-1:0];
            sat_next = 1'b0;
        end
    end

    // ---------------- output register and skid ----------------
    logic                    out_v_reg;
    logic signed [LVL_W-1:0] out_rx_reg;
    logic                    out_sat_reg;
    logic signed [LVL_W-1:0] skid_rx_reg;
    logic                    skid_sat_reg;
    logic                    pop;
    logic                    push;

    assign pop  = out_v_reg && m_ready;
    assign push = en && pr_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (pop) begin
                skid_v_reg <= 1'b0;
            end
        end else if (push && out_v_reg && !pop) begin
            skid_v_reg <= 1'b1;
        end else if (push) begin
            out_v_reg <= 1'b1;
        end else if (pop) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (pop) begin
                out_rx_reg  <= skid_rx_reg;
                out_sat_reg <= skid_sat_reg;
            end
        end else if (push && out_v_reg && !pop) begin
            // hold the waiting result, park the new one
            skid_rx_reg  <= rx_next;
            skid_sat_reg <= sat_next;
        end else if (push) begin
            out_rx_reg  <= rx_next;
            out_sat_reg <= sat_next;
        end
    end

    assign m_valid     = out_v_reg;
    assign m_rx_level  = out_rx_reg;
    assign m_saturated = out_sat_reg;

    // ---------------- assertions ----------------
    `RPLE_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_v_reg, out_v_reg)
    `RPLE_ASSERT_IMP(a_skid_fill_on_stall, aclk, aresetn, $rose(skid_v_reg), $past(out_v_reg) && !$past(m_ready))
    `RPLE_ASSERT_NXT(a_push_lands, aclk, aresetn, push, out_v_reg)
    `RPLE_ASSERT_IMP(a_sat_at_rail, aclk, aresetn, m_valid && m_saturated, m_rx_level == 16'sh7FFF || m_rx_level == 16'sh8000)

endmodule
